// ===== hdl/msgs_pkg.sv =====
// ----------------------------------------------------------------------------
// msgs_pkg
// Types, constants and the speaker layout table of the mono to surround
// gain spread core.
// ----------------------------------------------------------------------------
`default_nettype none

package msgs_pkg;

    localparam int C_MAX_CHANNELS = 8;

    localparam logic [3:0] C_CHAN_COUNT_RESET = 4'd2;

    // Q.15 speaker components: one and one over root two.
    localparam logic signed [16:0] C_ONE  = 17'sd32768;
    localparam logic signed [16:0] C_DIAG = 17'sd23170;
    localparam logic signed [16:0] C_ZERO = 17'sd0;

    // Spread weight 0.3, and 0.7 + 0.15 folded into one base.
    localparam logic signed [15:0] C_SPREAD    = 16'sd9830;
    localparam logic signed [17:0] C_GAIN_BASE = 18'sd27853;
    localparam logic signed [17:0] C_GAIN_MAX  = 18'sd32768;

    // Speaker positions.
    localparam logic [3:0] POS_FL  = 4'd0;
    localparam logic [3:0] POS_C   = 4'd1;
    localparam logic [3:0] POS_FR  = 4'd2;
    localparam logic [3:0] POS_SL  = 4'd3;
    localparam logic [3:0] POS_SR  = 4'd4;
    localparam logic [3:0] POS_RL  = 4'd5;
    localparam logic [3:0] POS_RR  = 4'd6;
    localparam logic [3:0] POS_RC  = 4'd7;
    localparam logic [3:0] POS_LFE = 4'd8;

    typedef struct packed {
        logic signed [15:0] sample;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_z;
    } t_req;

    typedef struct packed {
        logic [2:0]         channel_index;
        logic signed [15:0] out_sample;
        logic               last;
    } t_res;

    typedef struct packed {
        logic       valid;
        logic [2:0] ch;
        logic       last;
    } t_tag;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] z;
    } t_spk;

    function automatic logic [3:0] spk_pos(input logic [2:0] layout, input logic [2:0] ch);
        logic [3:0] pos;
        pos = POS_LFE;
        case (layout)
            3'd0: pos = POS_C;
            3'd1: pos = (ch == 3'd0) ? POS_FL : POS_FR;
            3'd2: begin
                case (ch)
                    3'd0:    pos = POS_FL;
                    3'd1:    pos = POS_C;
                    default: pos = POS_FR;
                endcase
            end
            3'd3: begin
                case (ch)
                    3'd0:    pos = POS_FL;
                    3'd1:    pos = POS_FR;
                    3'd2:    pos = POS_RL;
                    default: pos = POS_RR;
                endcase
            end
            3'd4, 3'd5: begin
                case (ch)
                    3'd0:    pos = POS_FL;
                    3'd1:    pos = POS_C;
                    3'd2:    pos = POS_FR;
                    3'd3:    pos = POS_RL;
                    3'd4:    pos = POS_RR;
                    default: pos = POS_LFE;
                endcase
            end
            3'd6: begin
                case (ch)
                    3'd0:    pos = POS_FL;
                    3'd1:    pos = POS_C;
                    3'd2:    pos = POS_FR;
                    3'd3:    pos = POS_SL;
                    3'd4:    pos = POS_SR;
                    3'd5:    pos = POS_RC;
                    default: pos = POS_LFE;
                endcase
            end
            default: begin
                case (ch)
                    3'd0:    pos = POS_FL;
                    3'd1:    pos = POS_C;
                    3'd2:    pos = POS_FR;
                    3'd3:    pos = POS_SL;
                    3'd4:    pos = POS_SR;
                    3'd5:    pos = POS_RL;
                    3'd6:    pos = POS_RR;
                    default: pos = POS_LFE;
                endcase
            end
        endcase
        return pos;
    endfunction

    function automatic t_spk spk_vec(input logic [2:0] layout, input logic [2:0] ch);
        t_spk v;
        v.x = C_ZERO;
        v.z = C_ZERO;
        case (spk_pos(layout, ch))
            POS_FL: begin
                v.x = -C_DIAG;
                v.z = -C_DIAG;
            end
            POS_C: begin
                v.z = -C_ONE;
            end
            POS_FR: begin
                v.x = C_DIAG;
                v.z = -C_DIAG;
            end
            POS_SL: begin
                v.x = -C_ONE;
            end
            POS_SR: begin
                v.x = C_ONE;
            end
            POS_RL: begin
                v.x = -C_DIAG;
                v.z = C_DIAG;
            end
            POS_RR: begin
                v.x = C_DIAG;
                v.z = C_DIAG;
            end
            POS_RC: begin
                v.z = C_ONE;
            end
            default: begin
                v.x = C_ZERO;
                v.z = C_ZERO;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mono_to_surround_gain_spread_core.sv =====
// ----------------------------------------------------------------------------
// mono_to_surround_gain_spread_core
// Spreads a mono sample over a speaker layout with direction-based gains.
// ----------------------------------------------------------------------------
// A request (sample, dir_x, dir_z) is taken on a clock edge with start high
// and busy low. It yields one result per active channel, in channel order,
// each shown on o_res for one cycle with o_strobe high; the final channel
// carries last. The receiver cannot hold results off, and none is needed.
// The channel count register (i_cfg_we, i_cfg_wdata) selects the layout
// from mono up to 7.1; zero acts as one and larger values as eight.
// The sequencer issues one channel per cycle, so a request of n channels
// occupies the sequencer until its last channel is issued. Busy is high
// while any channel but the last is issued; the next request may follow
// without a gap.
// Reset clears the pipeline and sets the channel count to two.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_to_surround_gain_spread_core
    import msgs_pkg::*;
#(
    parameter int MAX_CHANNELS = C_MAX_CHANNELS
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       start,
    output logic            busy,
    input  wire t_req       i_req,
    output logic            o_strobe,
    output t_res            o_res
);

    t_tag               seq_tag;
    logic [2:0]         seq_layout;
    t_req               seq_req;
    t_tag               gain_tag;
    logic signed [15:0] gain_sample;
    logic [15:0]        gain_value;

    msgs_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_tag       (seq_tag),
        .o_layout    (seq_layout),
        .o_req       (seq_req)
    );

    msgs_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (seq_tag),
        .i_layout (seq_layout),
        .i_req    (seq_req),
        .o_tag    (gain_tag),
        .o_sample (gain_sample),
        .o_gain   (gain_value)
    );

    msgs_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (gain_tag),
        .i_sample (gain_sample),
        .i_gain   (gain_value),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    a_first_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 (o_strobe && o_res.channel_index == 3'd0))
        else $error("Channel zero did not appear at the expected latency.");

    a_channel_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last) |=>
            (o_strobe && o_res.channel_index == $past(o_res.channel_index) + 3'd1))
        else $error("Channel results of one request are not contiguous.");
`endif

endmodule

`default_nettype wire

// ===== hdl/msgs_seq.sv =====
// ----------------------------------------------------------------------------
// msgs_seq
// Channel count register and request sequencer. Holds one request and
// issues one channel per cycle into the gain pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module msgs_seq
    import msgs_pkg::*;
#(
    parameter int MAX_CHANNELS = C_MAX_CHANNELS
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    input  wire logic       start,
    output logic            busy,
    input  wire t_req       i_req,
    output t_tag            o_tag,
    output logic [2:0]      o_layout,
    output t_req            o_req
);

    logic [3:0] r_chan_count;
    logic       r_active;
    logic [2:0] r_ch;
    logic [2:0] r_last_ch;
    t_req       r_req;

    logic [3:0] n_cnt_m1;
    logic [2:0] n_last_ch;
    logic       n_at_last;
    logic       n_accept;

    always_comb begin
        n_cnt_m1 = r_chan_count - 4'd1;
        if (r_chan_count == 4'd0) begin
            n_last_ch = 3'd0;
        end else if (r_chan_count > 4'(MAX_CHANNELS)) begin
            n_last_ch = 3'(MAX_CHANNELS - 1);
        end else begin
            n_last_ch = n_cnt_m1[2:0];
        end
    end

    assign n_at_last = (r_ch == r_last_ch);
    assign busy      = r_active && !n_at_last;
    assign n_accept  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= C_CHAN_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_chan_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (n_accept) begin
            r_active <= 1'b1;
        end else if (r_active && n_at_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_req     <= i_req;
            r_ch      <= 3'd0;
            r_last_ch <= n_last_ch;
        end else if (r_active && !n_at_last) begin
            r_ch <= r_ch + 3'd1;
        end
    end

    assign o_tag.valid = r_active;
    assign o_tag.ch    = r_ch;
    assign o_tag.last  = n_at_last;
    assign o_layout    = r_last_ch;
    assign o_req       = r_req;

endmodule

`default_nettype wire

// ===== hdl/msgs_gain.sv =====
// ----------------------------------------------------------------------------
// msgs_gain
// Four stage gain pipeline: direction products, dot product, spread
// product, and the rounded and clamped channel gain.
// ----------------------------------------------------------------------------
`default_nettype none

module msgs_gain
    import msgs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_tag               i_tag,
    input  wire logic [2:0]         i_layout,
    input  wire t_req               i_req,
    output t_tag                    o_tag,
    output logic signed [15:0]      o_sample,
    output logic [15:0]             o_gain
);

    localparam logic signed [47:0] C_HALF = 48'sh0000_4000_0000;

    t_spk n_spk;

    t_tag               r_tag1, r_tag2, r_tag3, r_tag4;
    logic signed [15:0] r_smp1, r_smp2, r_smp3, r_smp4;
    logic signed [32:0] r_px;
    logic signed [32:0] r_pz;
    logic signed [32:0] r_d;
    logic signed [47:0] r_p;
    logic [15:0]        r_gain;

    logic signed [47:0] n_round;
    logic signed [16:0] n_gq;
    logic signed [17:0] n_gfull;
    logic [15:0]        n_gain;

    assign n_spk = spk_vec(i_layout, i_tag.ch);

    always_comb begin
        n_round = r_p + C_HALF;
        n_gq    = n_round[47:31];
        n_gfull = {n_gq[16], n_gq} + C_GAIN_BASE;
        if (n_gfull > C_GAIN_MAX) begin
            n_gain = C_GAIN_MAX[15:0];
        end else begin
            n_gain = n_gfull[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
            r_tag4.valid <= 1'b0;
        end else begin
            r_tag1.valid <= i_tag.valid;
            r_tag2.valid <= r_tag1.valid;
            r_tag3.valid <= r_tag2.valid;
            r_tag4.valid <= r_tag3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1.ch   <= i_tag.ch;
        r_tag1.last <= i_tag.last;
        r_tag2.ch   <= r_tag1.ch;
        r_tag2.last <= r_tag1.last;
        r_tag3.ch   <= r_tag2.ch;
        r_tag3.last <= r_tag2.last;
        r_tag4.ch   <= r_tag3.ch;
        r_tag4.last <= r_tag3.last;
        r_smp1      <= i_req.sample;
        r_smp2      <= r_smp1;
        r_smp3      <= r_smp2;
        r_smp4      <= r_smp3;
        r_px        <= i_req.dir_x * n_spk.x;
        r_pz        <= i_req.dir_z * n_spk.z;
        r_d         <= r_px + r_pz;
        r_p         <= r_d * C_SPREAD;
        r_gain      <= n_gain;
    end

    assign o_tag    = r_tag4;
    assign o_sample = r_smp4;
    assign o_gain   = r_gain;

endmodule

`default_nettype wire

// ===== hdl/msgs_scale.sv =====
// ----------------------------------------------------------------------------
// msgs_scale
// Sample times gain, then rounding to Q1.15 into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msgs_scale
    import msgs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_tag               i_tag,
    input  wire logic signed [15:0] i_sample,
    input  wire logic [15:0]        i_gain,
    output logic                    o_strobe,
    output t_res                    o_res
);

    localparam logic signed [32:0] C_RND = 33'sd16384;

    t_tag               r_tag5;
    logic signed [32:0] r_y;
    logic               r_strobe;
    t_res               r_res;
    logic signed [32:0] n_round;

    assign n_round = r_y + C_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag5.valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_tag5.valid <= i_tag.valid;
            r_strobe     <= r_tag5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag5.ch           <= i_tag.ch;
        r_tag5.last         <= i_tag.last;
        r_y                 <= i_sample * $signed({1'b0, i_gain});
        r_res.channel_index <= r_tag5.ch;
        r_res.last          <= r_tag5.last;
        r_res.out_sample    <= n_round[30:15];
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire
